[hdl/sbeu_pkg.sv]
// ----------------------------------------------------------------------------
// sbeu_pkg
// Types and constants shared by the stack bytecode execute unit.
// ----------------------------------------------------------------------------
package sbeu_pkg;

    localparam int OP_W   = 5;
    localparam int WORD_W = 32;
    localparam int SLOT_W = 8;
    localparam int OFF_W  = 16;
    localparam int ST_W   = 3;
    localparam int OUT_PC_W = 16;
    localparam int CFG_W  = 9;
    localparam logic [WORD_W-1:0] INT_MIN_BITS = 32'h8000_0000;
    localparam int WORD_BITS = 32;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_ARITH    = 3'd1;
    localparam logic [ST_W-1:0] ST_LOCAL    = 3'd2;
    localparam logic [ST_W-1:0] ST_ASSERT   = 3'd3;
    localparam logic [ST_W-1:0] ST_THROWN   = 3'd4;
    localparam logic [ST_W-1:0] ST_STACK    = 3'd5;
    localparam logic [ST_W-1:0] ST_RETURNED = 3'd6;

    localparam logic [OP_W-1:0] OP_NOP    = 5'd0;
    localparam logic [OP_W-1:0] OP_POP    = 5'd1;
    localparam logic [OP_W-1:0] OP_DUP    = 5'd2;
    localparam logic [OP_W-1:0] OP_SWAP   = 5'd3;
    localparam logic [OP_W-1:0] OP_ADD    = 5'd4;
    localparam logic [OP_W-1:0] OP_SUB    = 5'd5;
    localparam logic [OP_W-1:0] OP_MUL    = 5'd6;
    localparam logic [OP_W-1:0] OP_DIV    = 5'd7;
    localparam logic [OP_W-1:0] OP_REM    = 5'd8;
    localparam logic [OP_W-1:0] OP_AND    = 5'd9;
    localparam logic [OP_W-1:0] OP_OR     = 5'd10;
    localparam logic [OP_W-1:0] OP_XOR    = 5'd11;
    localparam logic [OP_W-1:0] OP_SHL    = 5'd12;
    localparam logic [OP_W-1:0] OP_SHR    = 5'd13;
    localparam logic [OP_W-1:0] OP_BIPUSH = 5'd14;
    localparam logic [OP_W-1:0] OP_ILDC   = 5'd15;
    localparam logic [OP_W-1:0] OP_NULL   = 5'd16;
    localparam logic [OP_W-1:0] OP_VLOAD  = 5'd17;
    localparam logic [OP_W-1:0] OP_VSTORE = 5'd18;
    localparam logic [OP_W-1:0] OP_CMPEQ  = 5'd19;
    localparam logic [OP_W-1:0] OP_CMPNE  = 5'd20;
    localparam logic [OP_W-1:0] OP_LT     = 5'd21;
    localparam logic [OP_W-1:0] OP_GE     = 5'd22;
    localparam logic [OP_W-1:0] OP_GT     = 5'd23;
    localparam logic [OP_W-1:0] OP_LE     = 5'd24;
    localparam logic [OP_W-1:0] OP_GOTO   = 5'd25;
    localparam logic [OP_W-1:0] OP_ATHROW = 5'd26;
    localparam logic [OP_W-1:0] OP_ASSERT = 5'd27;
    localparam logic [OP_W-1:0] OP_RETURN = 5'd28;

    typedef enum logic [2:0]
    {
        CLS_MISC  = 3'd0,
        CLS_ALU   = 3'd1,
        CLS_DIV   = 3'd2,
        CLS_PUSH  = 3'd3,
        CLS_LOCAL = 3'd4,
        CLS_BRAN  = 3'd5
    } op_class_t;

    typedef struct packed
    {
        logic [OP_W-1:0]   op;
        op_class_t         cls;
        logic [1:0]        need;
        logic              room;
        logic [1:0]        len;
        logic [WORD_W-1:0] imm;
        logic [SLOT_W-1:0] slot;
        logic [OFF_W-1:0]  off;
    } decoded_t;

    function automatic decoded_t decode(input logic [OP_W-1:0] op,
                                        input logic [WORD_W-1:0] imm,
                                        input logic [SLOT_W-1:0] slot,
                                        input logic [OFF_W-1:0] off);
        decoded_t d;
        d.op = op;
        d.imm = imm;
        d.slot = slot;
        d.off = off;
        d.cls = CLS_MISC;
        d.need = 2'd0;
        d.room = 1'b0;
        d.len = 2'd1;
        case (op)
            OP_POP, OP_ATHROW: d.need = 2'd1;
            OP_DUP:
            begin
                d.need = 2'd1;
                d.room = 1'b1;
            end
            OP_SWAP, OP_ASSERT: d.need = 2'd2;
            OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR:
            begin
                d.need = 2'd2;
                d.cls = CLS_ALU;
            end
            OP_DIV, OP_REM:
            begin
                d.need = 2'd2;
                d.cls = CLS_DIV;
            end
            OP_BIPUSH:
            begin
                d.room = 1'b1;
                d.cls = CLS_PUSH;
                d.len = 2'd2;
            end
            OP_ILDC:
            begin
                d.room = 1'b1;
                d.cls = CLS_PUSH;
                d.len = 2'd3;
            end
            OP_NULL:
            begin
                d.room = 1'b1;
                d.cls = CLS_PUSH;
                d.imm = '0;
            end
            OP_VLOAD:
            begin
                d.room = 1'b1;
                d.cls = CLS_LOCAL;
                d.len = 2'd2;
            end
            OP_VSTORE:
            begin
                d.need = 2'd1;
                d.cls = CLS_LOCAL;
                d.len = 2'd2;
            end
            OP_CMPEQ, OP_CMPNE, OP_LT, OP_GE, OP_GT, OP_LE:
            begin
                d.need = 2'd2;
                d.cls = CLS_BRAN;
                d.len = 2'd3;
            end
            OP_GOTO:
            begin
                d.cls = CLS_BRAN;
                d.len = 2'd3;
            end
            default: d.cls = CLS_MISC;
        endcase
        return d;
    endfunction

endpackage

[hdl/sbeu_if.sv]
// ----------------------------------------------------------------------------
// sbeu channel interfaces
// Valid/ready channels for instructions, results and configuration.
// ----------------------------------------------------------------------------
interface sbeu_in_if;
    import sbeu_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [WORD_W-1:0] immediate;
    logic [SLOT_W-1:0] local_index;
    logic [OFF_W-1:0]  branch_offset;
    modport source (output valid, operation, immediate, local_index, branch_offset,
                    input ready);
    modport sink (input valid, operation, immediate, local_index, branch_offset,
                  output ready);
endinterface

interface sbeu_out_if;
    import sbeu_pkg::*;
    logic                valid;
    logic                ready;
    logic [ST_W-1:0]     status;
    logic [OUT_PC_W-1:0] next_pc;
    logic                branch_taken;
    logic [WORD_W-1:0]   top_value;
    modport source (output valid, status, next_pc, branch_taken, top_value,
                    input ready);
    modport sink (input valid, status, next_pc, branch_taken, top_value,
                  output ready);
endinterface

interface sbeu_cfg_if;
    import sbeu_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[hdl/sbeu_front.sv]
// ----------------------------------------------------------------------------
// sbeu_front
// Accept instructions, classify them and queue them for the back end.
// ----------------------------------------------------------------------------
module sbeu_front
    import sbeu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    sbeu_in_if.sink  in_ch,
    output logic     q_valid,
    input  logic     q_pop,
    output decoded_t q_data
);

    decoded_t   q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push = in_ch.valid && in_ch.ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= decode(in_ch.operation, in_ch.immediate,
                                            in_ch.local_index, in_ch.branch_offset);
    end

endmodule

[hdl/sbeu_divider.sv]
// ----------------------------------------------------------------------------
// sbeu_divider
// Radix-2 signed divider, quotient and remainder truncated toward zero.
// ----------------------------------------------------------------------------
module sbeu_divider
    import sbeu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quotient,
    output logic [WORD_W-1:0] remainder
);

    logic [WORD_W-1:0] q_reg, q_next;
    logic [WORD_W:0]   r_reg, r_next;
    logic [WORD_W-1:0] d_reg;
    logic              nq_reg, nr_reg;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   shifted;

    assign shifted = {r_reg[WORD_W-1:0], q_reg[WORD_W-1]};
    assign trial = shifted - {1'b0, d_reg};

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            if (trial[WORD_W])
            begin
                r_next = shifted;
                q_next = {q_reg[WORD_W-2:0], 1'b0};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[WORD_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= 6'd0;
            done <= 1'b0;
        end
        else
        begin
            done <= busy_reg && (cnt_reg == 6'd1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'(WORD_BITS);
            end
            else
            begin
                busy_reg <= busy_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend[WORD_W-1] ? -dividend : dividend;
            d_reg <= divisor[WORD_W-1] ? -divisor : divisor;
            r_reg <= '0;
            nq_reg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
            nr_reg <= dividend[WORD_W-1];
        end
        else
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quotient = nq_reg ? -q_reg : q_reg;
    assign remainder = nr_reg ? -r_reg[WORD_W-1:0] : r_reg[WORD_W-1:0];

endmodule

[hdl/sbeu_back.sv]
// ----------------------------------------------------------------------------
// sbeu_back
// Execute queued instructions against the stack, locals and program counter.
// ----------------------------------------------------------------------------
module sbeu_back
    import sbeu_pkg::*;
#(
    parameter int STACK_DEPTH  = 64,
    parameter int LOCALS_DEPTH = 256,
    parameter int PC_WIDTH     = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_pop,
    input  decoded_t         q_data,
    input  logic [CFG_W-1:0] locals_in_use,
    sbeu_out_if.source       out_ch
);

    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int SA_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LA_W  = (LOCALS_DEPTH > 1) ? $clog2(LOCALS_DEPTH) : 1;

    typedef enum logic [4:0]
    {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
    logic [WORD_W-1:0] locals_mem [LOCALS_DEPTH];

    logic [SP_W-1:0]     sp_reg;
    logic [PC_WIDTH-1:0] pc_reg;
    logic [ST_W-1:0]     halt_reg;
    logic [WORD_W-1:0]   top_reg;
    logic [WORD_W-1:0]   below_reg;
    logic [WORD_W-1:0]   local_rd_reg;
    decoded_t            cur_reg;
    logic                div_ok_reg;

    logic [ST_W-1:0]     o_status_reg;
    logic [OUT_PC_W-1:0] o_pc_reg;
    logic                o_taken_reg;
    logic [WORD_W-1:0]   o_top_reg;
    logic                o_valid_reg;

    logic              div_start, div_done;
    logic [WORD_W-1:0] div_q, div_r;

    logic [SP_W:0] sp_wide;
    logic          stack_bad;
    logic [8:0]    valid_slots;
    logic          slot_bad;
    logic [WORD_W-1:0] l, r, alu;
    logic          alu_bad;
    logic          div_bad;
    logic          cond;
    logic          lt_lr, lt_rl;

    logic [ST_W-1:0]     e_st;
    logic [SP_W-1:0]     e_sp;
    logic                e_taken;
    logic [WORD_W-1:0]   e_top;
    logic                wr_en;
    logic [SA_W-1:0]     wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic                wr2_en;
    logic [SA_W-1:0]     wr2_addr;
    logic [WORD_W-1:0]   wr2_data;
    logic                lw_en;
    logic                commit;
    logic [WORD_W-1:0]   div_res;

    sbeu_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (below_reg),
        .divisor   (top_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign out_ch.valid = o_valid_reg;
    assign out_ch.status = o_status_reg;
    assign out_ch.next_pc = o_pc_reg;
    assign out_ch.branch_taken = o_taken_reg;
    assign out_ch.top_value = o_top_reg;

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    assign sp_wide = {1'b0, sp_reg} + {{SP_W{1'b0}}, cur_reg.room};
    assign valid_slots = (locals_in_use < 9'(LOCALS_DEPTH)) ? locals_in_use
                                                            : 9'(LOCALS_DEPTH);
    assign slot_bad = {1'b0, cur_reg.slot} >= valid_slots;
    assign l = below_reg;
    assign r = top_reg;
    assign lt_lr = (l ^ INT_MIN_BITS) < (r ^ INT_MIN_BITS);
    assign lt_rl = (r ^ INT_MIN_BITS) < (l ^ INT_MIN_BITS);
    assign div_bad = (r == '0) || (r == '1 && l == INT_MIN_BITS);
    assign div_res = (cur_reg.op == OP_DIV) ? div_q : div_r;

    always_comb
    begin
        stack_bad = (sp_reg < SP_W'(cur_reg.need))
                 || (sp_wide > (SP_W+1)'(STACK_DEPTH))
                 || (cur_reg.op == OP_RETURN && sp_reg != SP_W'(1));
    end

    always_comb
    begin
        alu = '0;
        alu_bad = 1'b0;
        case (cur_reg.op)
            OP_ADD: alu = l + r;
            OP_SUB: alu = l - r;
            OP_MUL: alu = l * r;
            OP_AND: alu = l & r;
            OP_OR:  alu = l | r;
            OP_XOR: alu = l ^ r;
            OP_SHL:
            begin
                alu_bad = r >= 32'(WORD_BITS);
                alu = l << r[4:0];
            end
            OP_SHR:
            begin
                alu_bad = r >= 32'(WORD_BITS);
                alu = $signed(l) >>> r[4:0];
            end
            default: alu = '0;
        endcase
    end

    always_comb
    begin
        case (cur_reg.op)
            OP_CMPEQ: cond = (l == r);
            OP_CMPNE: cond = (l != r);
            OP_LT:    cond = lt_lr;
            OP_GE:    cond = !lt_lr;
            OP_GT:    cond = lt_rl;
            OP_LE:    cond = !lt_rl;
            default:  cond = 1'b1;
        endcase
    end

    // Resolve the step: e_top is the new top word.
    always_comb
    begin
        e_st = ST_OK;
        e_sp = sp_reg;
        e_taken = 1'b0;
        e_top = top_reg;
        wr_en = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        wr2_en = 1'b0;
        wr2_addr = '0;
        wr2_data = '0;
        lw_en = 1'b0;
        if (halt_reg != ST_OK)
            e_st = halt_reg;
        else if (stack_bad)
            e_st = ST_STACK;
        else
        begin
            case (cur_reg.cls)
                CLS_ALU:
                begin
                    if (alu_bad)
                        e_st = ST_ARITH;
                    else
                    begin
                        e_sp = sp_reg - SP_W'(1);
                        e_top = alu;
                        wr_en = 1'b1;
                        wr_addr = SA_W'(sp_reg - SP_W'(2));
                        wr_data = alu;
                    end
                end
                CLS_DIV:
                begin
                    if (div_bad)
                        e_st = ST_ARITH;
                    else
                    begin
                        e_sp = sp_reg - SP_W'(1);
                        e_top = div_res;
                        wr_en = 1'b1;
                        wr_addr = SA_W'(sp_reg - SP_W'(2));
                        wr_data = div_res;
                    end
                end
                CLS_PUSH:
                begin
                    e_sp = sp_reg + SP_W'(1);
                    e_top = cur_reg.imm;
                    wr_en = 1'b1;
                    wr_addr = SA_W'(sp_reg);
                    wr_data = cur_reg.imm;
                end
                CLS_LOCAL:
                begin
                    if (slot_bad)
                        e_st = ST_LOCAL;
                    else if (cur_reg.op == OP_VLOAD)
                    begin
                        e_sp = sp_reg + SP_W'(1);
                        e_top = local_rd_reg;
                        wr_en = 1'b1;
                        wr_addr = SA_W'(sp_reg);
                        wr_data = local_rd_reg;
                    end
                    else
                    begin
                        e_sp = sp_reg - SP_W'(1);
                        e_top = below_reg;
                        lw_en = 1'b1;
                    end
                end
                CLS_BRAN:
                begin
                    e_taken = cond;
                    if (cur_reg.op != OP_GOTO)
                    begin
                        e_sp = sp_reg - SP_W'(2);
                        e_top = '0;
                    end
                end
                default:
                begin
                    case (cur_reg.op)
                        OP_POP:
                        begin
                            e_sp = sp_reg - SP_W'(1);
                            e_top = below_reg;
                        end
                        OP_DUP:
                        begin
                            e_sp = sp_reg + SP_W'(1);
                            wr_en = 1'b1;
                            wr_addr = SA_W'(sp_reg);
                            wr_data = top_reg;
                        end
                        OP_SWAP:
                        begin
                            e_top = below_reg;
                            wr_en = 1'b1;
                            wr_addr = SA_W'(sp_reg - SP_W'(1));
                            wr_data = below_reg;
                            wr2_en = 1'b1;
                            wr2_addr = SA_W'(sp_reg - SP_W'(2));
                            wr2_data = top_reg;
                        end
                        OP_ATHROW: e_st = ST_THROWN;
                        OP_ASSERT:
                        begin
                            if (below_reg == '0)
                                e_st = ST_ASSERT;
                            else
                            begin
                                e_sp = sp_reg - SP_W'(2);
                                e_top = '0;
                            end
                        end
                        OP_RETURN: e_st = ST_RETURNED;
                        default: e_st = ST_OK;
                    endcase
                end
            endcase
        end
        commit = (e_st == ST_OK);
    end

    logic [WORD_W-1:0] third_reg;
    logic [PC_WIDTH-1:0] pc_step;
    always_comb
    begin
        pc_step = e_taken ? PC_WIDTH'($signed(cur_reg.off))
                          : PC_WIDTH'(cur_reg.len);
    end

    always_comb
    begin
        state_next = state_reg;
        div_start = 1'b0;
        case (state_reg)
            S_IDLE:  if (q_valid) state_next = S_READ;
            S_READ:  state_next = S_EXEC;
            S_EXEC:
            begin
                if (halt_reg == ST_OK && !stack_bad && cur_reg.cls == CLS_DIV && !div_bad
                    && !div_ok_reg)
                begin
                    div_start = 1'b1;
                    state_next = S_DIV;
                end
                else if (!o_valid_reg || out_ch.ready)
                    state_next = S_OUT;
            end
            S_DIV:   if (div_done) state_next = S_EXEC;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    logic fin;
    assign fin = (state_reg == S_EXEC) && (state_next == S_OUT);

    // The new top word: after a pop of two, the word that was at sp-3.
    logic [WORD_W-1:0] e_top_final;
    always_comb
    begin
        e_top_final = e_top;
        if (commit && (cur_reg.cls == CLS_BRAN && cur_reg.op != OP_GOTO
                       || cur_reg.op == OP_ASSERT))
            e_top_final = (e_sp == '0) ? '0 : third_reg;
        else if (commit && (cur_reg.cls == CLS_ALU || cur_reg.cls == CLS_DIV
                            || cur_reg.op == OP_POP || cur_reg.op == OP_VSTORE))
            e_top_final = (e_sp == '0) ? '0 : ((cur_reg.op == OP_POP
                           || cur_reg.op == OP_VSTORE) ? below_reg : e_top);
        else if (!commit)
            e_top_final = (sp_reg == '0) ? '0 : top_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg <= '0;
            pc_reg <= '0;
            halt_reg <= ST_OK;
            o_valid_reg <= 1'b0;
            div_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DIV && div_done)
                div_ok_reg <= 1'b1;
            else if (fin)
                div_ok_reg <= 1'b0;
            if (o_valid_reg && out_ch.ready)
                o_valid_reg <= 1'b0;
            if (fin)
            begin
                o_valid_reg <= 1'b1;
                if (commit)
                begin
                    sp_reg <= e_sp;
                    pc_reg <= pc_reg + pc_step;
                end
                else
                    halt_reg <= e_st;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
            third_reg <= (sp_reg >= SP_W'(3)) ? stack_mem[SA_W'(sp_reg - SP_W'(3))] : '0;
        end
        if (state_reg == S_READ)
        begin
            top_reg <= (sp_reg >= SP_W'(1)) ? stack_mem[SA_W'(sp_reg - SP_W'(1))] : '0;
            below_reg <= (sp_reg >= SP_W'(2)) ? stack_mem[SA_W'(sp_reg - SP_W'(2))] : '0;
            local_rd_reg <= locals_mem[LA_W'(cur_reg.slot)];
        end
        if (fin)
        begin
            if (wr_en)
                stack_mem[wr_addr] <= wr_data;
            if (wr2_en)
                stack_mem[wr2_addr] <= wr2_data;
            if (lw_en)
                locals_mem[LA_W'(cur_reg.slot)] <= top_reg;
            o_status_reg <= e_st;
            o_pc_reg <= OUT_PC_W'(commit ? pc_reg + pc_step : pc_reg);
            o_taken_reg <= commit && e_taken;
            o_top_reg <= e_top_final;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (halt_reg != ST_OK) |=> (halt_reg == $past(halt_reg)))
        else $error("sticky status changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (halt_reg != ST_OK) |=> $stable(sp_reg) && $stable(pc_reg))
        else $error("state moved while halted");
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == S_EXEC))
        else $error("divider started outside execute");

endmodule

[hdl/stack_bytecode_execute_unit_core.sv]
// ----------------------------------------------------------------------------
// stack_bytecode_execute_unit_core
// Stack bytecode execute unit: decoded instruction in, step result out.
//
//   channel  | dir | payload
//   in_ch    | in  | operation, immediate, local_index, branch_offset
//   out_ch   | out | status, next_pc, branch_taken, top_value
//   cfg_ch   | in  | data = locals_in_use
//
// The back end takes one item at a time: queue pop, stack read, execute, result;
// div and rem run the radix-2 divider between execute and a second execute.
// A two-entry queue lets the front accept while the back executes.
// Reset clears stack pointer, pc and status; stack and locals need no clear.
// ----------------------------------------------------------------------------
module stack_bytecode_execute_unit_core
    import sbeu_pkg::*;
#(
    parameter int STACK_DEPTH  = 64,
    parameter int LOCALS_DEPTH = 256,
    parameter int PC_WIDTH     = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    sbeu_in_if.sink    in_ch,
    sbeu_out_if.source out_ch,
    sbeu_cfg_if.sink   cfg_ch
);

    logic             q_valid;
    logic             q_pop;
    decoded_t         q_data;
    logic [CFG_W-1:0] locals_in_use_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            locals_in_use_reg <= 9'd256;
        else if (cfg_ch.valid)
            locals_in_use_reg <= cfg_ch.data;
    end

    sbeu_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data)
    );

    sbeu_back #(
        .STACK_DEPTH  (STACK_DEPTH),
        .LOCALS_DEPTH (LOCALS_DEPTH),
        .PC_WIDTH     (PC_WIDTH)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_data        (q_data),
        .locals_in_use (locals_in_use_reg),
        .out_ch        (out_ch)
    );

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the stack bytecode execute unit. A predictor keeps its own
// stack, locals, program counter and halt status and works out every result.
// Directed programs cover the extremes and each operation but pop, athrow and
// return. Random programs that stay free of faults follow, under several locals
// limits. One fault then halts the unit and the freeze is checked. Both sides
// stall at random.
module tb_top;
    import sbeu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 64;
    localparam int SLOTS      = 256;
    localparam int DRAIN      = 60;
    localparam int STALL_MAX  = 2000;
    localparam int RAND_ITEMS = 1600;

    typedef struct packed
    {
        logic [ST_W-1:0]     status;
        logic [OUT_PC_W-1:0] pc;
        logic                taken;
        logic [WORD_W-1:0]   top;
    } step_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sbeu_in_if  in_ch();
    sbeu_out_if out_ch();
    sbeu_cfg_if cfg_ch();

    stack_bytecode_execute_unit_core u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [WORD_W-1:0]   stk [DEPTH];
    logic [WORD_W-1:0]   locs [SLOTS];
    bit                  written [SLOTS];
    int                  sp;
    logic [OUT_PC_W-1:0] pc;
    logic [ST_W-1:0]     halt;
    logic [CFG_W-1:0]    locals_limit;

    step_result_t expected_q [$];
    int  errors;
    int  results_seen;
    int  stall_cycles;
    bit  idle_on;
    bit  ops_seen [32];

    function automatic logic [WORD_W-1:0] top_word();
        if (sp == 0)
        begin
            return '0;
        end
        return stk[sp-1];
    endfunction

    // Execute one instruction; state changes only when commit is set.
    function automatic step_result_t execute(input logic [OP_W-1:0] op,
                                             input logic [WORD_W-1:0] imm,
                                             input logic [SLOT_W-1:0] slot,
                                             input logic [OFF_W-1:0] off,
                                             input bit commit);
        step_result_t      r;
        logic [ST_W-1:0]   st;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] v;
        int                need;
        int                room;
        int                len;
        int                valid_slots;
        bit                taken;
        r = '0;
        st = ST_OK;
        a = '0;
        b = '0;
        v = '0;
        need = 0;
        room = 0;
        len = 1;
        taken = 1'b0;
        valid_slots = (locals_limit < SLOTS) ? int'(locals_limit) : SLOTS;
        if (halt != ST_OK)
        begin
            r.status = halt;
            r.pc = pc;
            r.top = top_word();
            return r;
        end
        case (op)
            OP_POP, OP_VSTORE, OP_ATHROW: need = 1;
            OP_DUP:
            begin
                need = 1;
                room = 1;
            end
            OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_AND, OP_OR, OP_XOR,
            OP_SHL, OP_SHR, OP_CMPEQ, OP_CMPNE, OP_LT, OP_GE, OP_GT, OP_LE,
            OP_ASSERT: need = 2;
            OP_BIPUSH, OP_ILDC, OP_NULL, OP_VLOAD: room = 1;
            default: need = 0;
        endcase
        if (sp < need || sp + room > DEPTH || (op == OP_RETURN && sp != 1))
        begin
            st = ST_STACK;
        end
        else
        begin
            if (sp >= 1)
            begin
                a = stk[sp-1];
            end
            if (sp >= 2)
            begin
                b = stk[sp-2];
            end
        end
        if (st == ST_OK)
        begin
            case (op)
                OP_POP:
                begin
                    if (commit)
                    begin
                        sp--;
                    end
                end
                OP_DUP:
                begin
                    if (commit)
                    begin
                        stk[sp] = a;
                        sp++;
                    end
                end
                OP_SWAP:
                begin
                    if (commit)
                    begin
                        stk[sp-1] = b;
                        stk[sp-2] = a;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_AND, OP_OR, OP_XOR,
                OP_SHL, OP_SHR:
                begin
                    case (op)
                        OP_ADD: v = b + a;
                        OP_SUB: v = b - a;
                        OP_MUL: v = b * a;
                        OP_AND: v = b & a;
                        OP_OR:  v = b | a;
                        OP_XOR: v = b ^ a;
                        OP_DIV, OP_REM:
                        begin
                            if (a == '0 || (a == '1 && b == INT_MIN_BITS))
                            begin
                                st = ST_ARITH;
                            end
                            else if (op == OP_DIV)
                            begin
                                v = $signed(b) / $signed(a);
                            end
                            else
                            begin
                                v = $signed(b) % $signed(a);
                            end
                        end
                        default:
                        begin
                            if (a >= WORD_BITS)
                            begin
                                st = ST_ARITH;
                            end
                            else if (op == OP_SHL)
                            begin
                                v = b << a[4:0];
                            end
                            else
                            begin
                                v = $signed(b) >>> a[4:0];
                            end
                        end
                    endcase
                    if (st == ST_OK && commit)
                    begin
                        sp--;
                        stk[sp-1] = v;
                    end
                end
                OP_BIPUSH, OP_ILDC, OP_NULL:
                begin
                    len = (op == OP_BIPUSH) ? 2 : (op == OP_ILDC) ? 3 : 1;
                    if (commit)
                    begin
                        stk[sp] = (op == OP_NULL) ? '0 : imm;
                        sp++;
                    end
                end
                OP_VLOAD, OP_VSTORE:
                begin
                    len = 2;
                    if (int'(slot) >= valid_slots)
                    begin
                        st = ST_LOCAL;
                    end
                    else if (commit && op == OP_VLOAD)
                    begin
                        stk[sp] = locs[slot];
                        sp++;
                    end
                    else if (commit)
                    begin
                        locs[slot] = a;
                        written[slot] = 1'b1;
                        sp--;
                    end
                end
                OP_CMPEQ, OP_CMPNE, OP_LT, OP_GE, OP_GT, OP_LE:
                begin
                    len = 3;
                    case (op)
                        OP_CMPEQ: taken = (b == a);
                        OP_CMPNE: taken = (b != a);
                        OP_LT:    taken = ($signed(b) < $signed(a));
                        OP_GE:    taken = ($signed(b) >= $signed(a));
                        OP_GT:    taken = ($signed(b) > $signed(a));
                        default:  taken = ($signed(b) <= $signed(a));
                    endcase
                    if (commit)
                    begin
                        sp -= 2;
                    end
                end
                OP_GOTO:
                begin
                    len = 3;
                    taken = 1'b1;
                end
                OP_ATHROW: st = ST_THROWN;
                OP_ASSERT:
                begin
                    if (b == '0)
                    begin
                        st = ST_ASSERT;
                    end
                    else if (commit)
                    begin
                        sp -= 2;
                    end
                end
                OP_RETURN: st = ST_RETURNED;
                default: len = 1;
            endcase
        end
        if (st != ST_OK)
        begin
            taken = 1'b0;
            if (commit)
            begin
                halt = st;
            end
        end
        else if (commit)
        begin
            pc = taken ? pc + off : pc + OUT_PC_W'(len);
        end
        r.status = st;
        r.pc = (st == ST_OK && !commit) ? (taken ? pc + off : pc + OUT_PC_W'(len)) : pc;
        r.taken = taken;
        r.top = top_word();
        return r;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] imm,
                             input logic [SLOT_W-1:0] slot, input logic [OFF_W-1:0] off);
        int gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        expected_q.push_back(execute(op, imm, slot, off, 1'b1));
        ops_seen[op] = 1'b1;
        in_ch.operation     <= op;
        in_ch.immediate     <= imm;
        in_ch.local_index   <= slot;
        in_ch.branch_offset <= off;
        in_ch.valid         <= 1'b1;
        @(posedge clk);
        while (!(in_ch.valid && in_ch.ready))
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_locals_limit(input logic [CFG_W-1:0] value);
        drain();
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready))
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        locals_limit = value;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return INT_MIN_BITS;
            1: return 32'h7FFF_FFFF;
            2: return '1;
            3: return WORD_W'($urandom_range(0, 40));
            default: return $urandom();
        endcase
    endfunction

    // Draw one instruction that runs without a fault and reads no unwritten slot.
    task automatic send_clean_item();
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] imm;
        logic [SLOT_W-1:0] slot;
        logic [OFF_W-1:0]  off;
        step_result_t      r;
        bit                ok;
        ok = 1'b0;
        for (int tries = 0; tries < 30 && !ok; tries++)
        begin
            if (sp < 3 && $urandom_range(0, 1) == 0)
            begin
                op = $urandom_range(0, 1) ? OP_BIPUSH : OP_ILDC;
            end
            else if (sp > DEPTH - 4 && $urandom_range(0, 1) == 0)
            begin
                op = OP_POP;
            end
            else
            begin
                op = OP_W'($urandom_range(0, 31));
            end
            imm  = pick_word();
            slot = $urandom_range(0, 3) == 0 ? SLOT_W'($urandom())
                                             : SLOT_W'($urandom_range(0, 7));
            off  = OFF_W'($urandom());
            r = execute(op, imm, slot, off, 1'b0);
            ok = (r.status == ST_OK) &&
                 !(op == OP_VLOAD && !written[slot]);
        end
        if (!ok)
        begin
            op = OP_NOP;
        end
        send_item(op, imm, slot, off);
    endtask

    task automatic test_directed();
        idle_on = 1'b0;
        send_item(OP_NULL, 32'h1234_5678, 8'd0, 16'd0);
        send_item(OP_BIPUSH, INT_MIN_BITS, 8'd0, 16'd0);
        send_item(OP_ILDC, 32'h7FFF_FFFF, 8'd0, 16'd0);
        send_item(OP_ADD, '0, 8'd0, 16'd0);
        send_item(OP_DUP, '0, 8'd0, 16'd0);
        send_item(OP_VSTORE, '0, 8'd255, 16'd0);
        send_item(OP_VLOAD, '0, 8'd255, 16'd0);
        send_item(OP_MUL, '0, 8'd0, 16'd0);
        send_item(OP_ILDC, 32'hFFFF_FFF9, 8'd0, 16'd0);
        send_item(OP_SWAP, '0, 8'd0, 16'd0);
        send_item(OP_DIV, '0, 8'd0, 16'd0);
        send_item(OP_BIPUSH, 32'd3, 8'd0, 16'd0);
        send_item(OP_REM, '0, 8'd0, 16'd0);
        send_item(OP_BIPUSH, 32'd31, 8'd0, 16'd0);
        send_item(OP_SHR, '0, 8'd0, 16'd0);
        send_item(OP_BIPUSH, 32'd31, 8'd0, 16'd0);
        send_item(OP_SHL, '0, 8'd0, 16'd0);
        send_item(OP_DUP, '0, 8'd0, 16'd0);
        send_item(OP_CMPEQ, '0, 8'd0, 16'h7FFF);
        send_item(OP_GOTO, '0, 8'd0, 16'h8000);
        send_item(5'd29, '0, 8'd0, 16'd0);
        send_item(5'd31, '0, 8'd0, 16'd0);
        send_item(OP_NOP, '0, 8'd0, 16'd0);
        send_item(OP_VSTORE, '0, 8'd0, 16'd0);
        send_item(OP_VLOAD, '0, 8'd0, 16'd0);
        for (logic [OP_W-1:0] op = OP_SUB; op <= OP_LE; op++)
        begin
            if (op == OP_BIPUSH)
            begin
                op = OP_CMPEQ;
            end
            send_item(OP_BIPUSH, pick_word(), 8'd0, 16'd0);
            send_item(OP_BIPUSH, WORD_W'($urandom_range(1, 31)), 8'd0, 16'd0);
            send_item(op, '0, 8'd0, OFF_W'($urandom()));
        end
        send_item(OP_BIPUSH, 32'd1, 8'd0, 16'd0);
        send_item(OP_BIPUSH, 32'd9, 8'd0, 16'd0);
        send_item(OP_ASSERT, '0, 8'd0, 16'd0);
    endtask

    task automatic test_random_programs();
        logic [CFG_W-1:0] limits [4];
        limits = '{9'd256, 9'd1, 9'd511, 9'd137};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_locals_limit(ph == 3 ? CFG_W'($urandom_range(2, 255)) : limits[ph]);
            for (int i = 0; i < RAND_ITEMS / 4; i++)
            begin
                idle_on = (i % 100) >= 30;
                send_clean_item();
            end
        end
    endtask

    task automatic test_halt_freeze();
        int kind;
        kind = $urandom_range(0, 8);
        idle_on = 1'b1;
        write_locals_limit(9'd1);
        case (kind)
            0, 7, 8:
            begin
                send_item(OP_ILDC, kind == 7 ? INT_MIN_BITS : $urandom(), 8'd0, 16'd0);
                send_item(OP_ILDC, kind == 7 ? '1 : kind == 0 ? '0 : 32'd32 + $urandom_range(0, 99),
                          8'd0, 16'd0);
                send_item(kind == 8 ? OP_SHR : $urandom_range(0, 1) ? OP_DIV : OP_REM,
                          '0, 8'd0, 16'd0);
            end
            1: send_item($urandom_range(0, 1) ? OP_VLOAD : OP_VSTORE, '0,
                         SLOT_W'($urandom_range(1, 255)), 16'd0);
            2:
            begin
                send_item(OP_NULL, '0, 8'd0, 16'd0);
                send_item(OP_ILDC, $urandom(), 8'd0, 16'd0);
                send_item(OP_ASSERT, '0, 8'd0, 16'd0);
            end
            3:
            begin
                send_item(OP_ILDC, $urandom(), 8'd0, 16'd0);
                send_item(OP_ATHROW, '0, 8'd0, 16'd0);
            end
            4:
            begin
                while (sp > 0)
                begin
                    send_item(OP_POP, '0, 8'd0, 16'd0);
                end
                send_item(OP_POP, '0, 8'd0, 16'd0);
            end
            5:
            begin
                while (halt == ST_OK)
                begin
                    send_item(OP_BIPUSH, $urandom(), 8'd0, 16'd0);
                end
            end
            default:
            begin
                while (sp > 1)
                begin
                    send_item(OP_POP, '0, 8'd0, 16'd0);
                end
                if (sp == 0)
                begin
                    send_item(OP_ILDC, $urandom(), 8'd0, 16'd0);
                end
                send_item(OP_RETURN, '0, 8'd0, 16'd0);
            end
        endcase
        for (int i = 0; i < 12; i++)
        begin
            send_item($urandom_range(0, 1) ? OP_GOTO : OP_BIPUSH, $urandom(),
                      8'd0, OFF_W'($urandom()));
        end
    endtask

    initial
    begin
        int ops_hit;
        in_ch.valid = 1'b0;
        in_ch.operation = '0;
        in_ch.immediate = '0;
        in_ch.local_index = '0;
        in_ch.branch_offset = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        sp = 0;
        pc = '0;
        halt = ST_OK;
        locals_limit = 9'd256;
        errors = 0;
        results_seen = 0;
        idle_on = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_programs();
        test_halt_freeze();
        drain();
        ops_hit = 0;
        foreach (ops_seen[i])
        begin
            ops_hit += ops_seen[i];
        end
        $display("Checked %0d results over %0d operation codes, locals limits 1 to 511,",
                 results_seen, ops_hit);
        $display("ending with a halt of status %0d and its freeze.", halt);
        if (errors == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            gap = idle_on ? $urandom_range(0, 12) : 0;
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(out_ch.valid && out_ch.ready))
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        step_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: status %0d pc %h top %h",
                         $time, out_ch.status, out_ch.next_pc, out_ch.top_value);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_ch.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_ch.status);
                    errors++;
                end
                if (out_ch.next_pc !== want.pc)
                begin
                    $display("%0t: next_pc expected %h actual %h",
                             $time, want.pc, out_ch.next_pc);
                    errors++;
                end
                if (out_ch.branch_taken !== want.taken)
                begin
                    $display("%0t: branch_taken expected %b actual %b",
                             $time, want.taken, out_ch.branch_taken);
                    errors++;
                end
                if (out_ch.top_value !== want.top)
                begin
                    $display("%0t: top_value expected %h actual %h",
                             $time, want.top, out_ch.top_value);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_MAX)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
            $display("tb_top: done, errors");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial stall_cycles = 0;

endmodule

[stack_bytecode_execute_unit_core.f]
hdl/sbeu_pkg.sv
hdl/sbeu_if.sv
hdl/sbeu_front.sv
hdl/sbeu_divider.sv
hdl/sbeu_back.sv
hdl/stack_bytecode_execute_unit_core.sv
test/tb_top.sv
